@@ hw/rtl/md5_message_digest_defines.svh @@
// Assertion macros used by the checker file.
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define MD5_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hw/rtl/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, round constants and helper functions of the MD5 block.
// ----------------------------------------------------------------------------
package md5_pkg;

	localparam int QDepth = 4;
	localparam int QAw = $clog2(QDepth);

	// One classified input transaction passed from front to back.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} md5_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_PAD,
		ST_OUT
	} md5_state_t;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			case (i)
				6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756;
				6'd2: k = 32'h242070db; 6'd3: k = 32'hc1bdceee;
				6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
				6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501;
				6'd8: k = 32'h698098d8; 6'd9: k = 32'h8b44f7af;
				6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
				6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
				6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
				6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
				6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
				6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
				6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
				6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
				6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
				6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
				6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
				6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
				6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
				6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
				6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
				6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
				6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
				6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
				6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
				6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
				6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
				6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
				6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
				6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
				6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
				6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
				6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
			endcase
			return k;
		end
	endfunction

	// Rotate amount for round i.
	function automatic logic [4:0] round_s(input logic [5:0] i);
		logic [4:0] s;
		begin
			case ({i[5:4], i[1:0]})
				4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
				4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
				4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
				4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; default: s = 5'd21;
			endcase
			return s;
		end
	endfunction

	// Message word index for round i.
	function automatic logic [3:0] round_g(input logic [5:0] i);
		logic [3:0] g;
		begin
			case (i[5:4])
				2'd0: g = i[3:0];
				2'd1: g = 4'(5 * i[3:0] + 1);
				2'd2: g = 4'(3 * i[3:0] + 5);
				default: g = 4'(7 * i[3:0]);
			endcase
			return g;
		end
	endfunction

endpackage

@@ hw/rtl/md5_front.sv @@
// ----------------------------------------------------------------------------
// MD5 front end
// Accepts input transactions, drops empty ones and queues the rest.
// ----------------------------------------------------------------------------
module md5_front import md5_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  md5_item_t in_item,
	output logic      q_valid,
	input  logic      q_pop,
	output md5_item_t q_item
);

	md5_item_t       mem_q [QDepth];
	logic [QAw-1:0]  wr_q, rd_q;
	logic [QAw:0]    cnt_q;
	logic            push;

	assign in_ready = (cnt_q != (QAw+1)'(QDepth));
	// Items with neither byte nor last do nothing and are dropped here.
	assign push = in_valid && in_ready && (in_item.has_byte || in_item.last);
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QAw+1)'(push) - (QAw+1)'(q_pop);
		end
	end

endmodule

@@ hw/rtl/md5_back.sv @@
// ----------------------------------------------------------------------------
// MD5 back end
// Buffers bytes, runs the one-round-per-cycle compression, pads and emits.
// ----------------------------------------------------------------------------
module md5_back import md5_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  md5_item_t   q_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	md5_state_t state_q, state_d;
	logic [31:0] msg_q [16];
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  rnd_q;
	logic [60:0] cnt_q;
	logic        fin_q;      // message is being finished
	logic        pad_q;      // the block in the rounds is a padding block
	logic        second_q;   // a length-only block still follows
	logic [1:0]  oidx_q;

	logic [5:0]  pos;
	logic        take;
	logic [31:0] f, sum, rot, new_b;
	logic        full;
	logic        len_here;
	logic [31:0] pad_msg [16];

	assign pos = cnt_q[5:0];
	assign take = (state_q == ST_IDLE) && q_valid;
	assign q_pop = take;
	assign full = q_item.has_byte && (pos == 6'd63);
	assign len_here = second_q || (pos < 6'd56);

	// Round function.
	always_comb begin
		case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum = a_q + f + round_k(rnd_q) + msg_q[round_g(rnd_q)];
		rot = (sum << round_s(rnd_q)) | (sum >> (6'd32 - {1'b0, round_s(rnd_q)}));
		new_b = b_q + rot;
	end

	// Padding block: bytes held so far, the pad byte, zero fill and the bit length.
	always_comb begin
		for (int w = 0; w < 16; w++) begin
			for (int y = 0; y < 4; y++) begin
				if (second_q || 6'(4*w+y) > pos) pad_msg[w][8*y +: 8] = 8'h00;
				else if (6'(4*w+y) == pos) pad_msg[w][8*y +: 8] = PAD_BYTE;
				else pad_msg[w][8*y +: 8] = msg_q[w][8*y +: 8];
			end
		end
		if (len_here) begin
			pad_msg[14] = {cnt_q[28:0], 3'b000};
			pad_msg[15] = cnt_q[60:29];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (take) begin
				if (full) state_d = ST_ROUND;
				else if (q_item.last) state_d = ST_PAD;
			end
			ST_ROUND: if (rnd_q == 6'd63) begin
				if (!fin_q) state_d = ST_IDLE;
				else if (pad_q && !second_q) state_d = ST_OUT;
				else state_d = ST_PAD;
			end
			ST_PAD: state_d = ST_ROUND;
			ST_OUT: if (out_ready && oidx_q == 2'd3) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		out_valid = (state_q == ST_OUT);
		digest_word = h_q[oidx_q];
		word_index = oidx_q;
		last_word = (oidx_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Message words: bytes land as they arrive, the padding block replaces them.
	always_ff @(posedge clk) begin
		if (take && q_item.has_byte) begin
			msg_q[pos[5:2]][8*pos[1:0] +: 8] <= q_item.data_byte;
		end else if (state_q == ST_PAD) begin
			for (int w = 0; w < 16; w++) msg_q[w] <= pad_msg[w];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= IV_A; h_q[1] <= IV_B; h_q[2] <= IV_C; h_q[3] <= IV_D;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
			cnt_q <= '0; fin_q <= 1'b0; pad_q <= 1'b0; second_q <= 1'b0;
			oidx_q <= '0; rnd_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (take) begin
					fin_q <= q_item.last;
					pad_q <= 1'b0;
					if (q_item.has_byte) begin
						cnt_q <= cnt_q + 61'd1;
					end
					rnd_q <= '0;
					a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
				end
				ST_PAD: begin
					second_q <= !len_here;
					pad_q <= 1'b1;
					rnd_q <= '0;
					a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
				end
				ST_ROUND: begin
					a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= new_b;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						h_q[0] <= h_q[0] + d_q;
						h_q[1] <= h_q[1] + new_b;
						h_q[2] <= h_q[2] + b_q;
						h_q[3] <= h_q[3] + c_q;
					end
				end
				ST_OUT: if (out_ready) begin
					oidx_q <= oidx_q + 2'd1;
					if (oidx_q == 2'd3) begin
						h_q[0] <= IV_A; h_q[1] <= IV_B; h_q[2] <= IV_C; h_q[3] <= IV_D;
						cnt_q <= '0; fin_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/md5_message_digest.sv @@
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-stream MD5 hash core with padding and a four-word digest output.
// ----------------------------------------------------------------------------
// The back end takes bytes only while idle; a byte that fills a 64-byte block
// then starts 64 rounds, one round per cycle through a single round unit. At
// the end of a message each padding block (one or two) is built in the pad
// state and then runs 64 rounds, and the digest leaves as four output
// transactions. Transactions with neither a byte nor the last flag are
// dropped by the front end. A four-entry queue lets input be taken while the
// core works.
module md5_message_digest import md5_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] has_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] digest_word
	output logic [1:0]  m_tuser,  // [1:0] word_index
	output logic        m_tlast
);

	md5_item_t in_item, q_item;
	logic      q_valid, q_pop;

	assign in_item = '{data_byte: s_tdata, has_byte: s_tuser, last: s_tlast};

	md5_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
		.q_valid, .q_pop, .q_item
	);

	md5_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.out_valid(m_tvalid), .out_ready(m_tready),
		.digest_word(m_tdata), .word_index(m_tuser), .last_word(m_tlast)
	);

endmodule

@@ hw/rtl/md5_checker.sv @@
// ----------------------------------------------------------------------------
// MD5 port checker
// Checks the output sequencing seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "md5_message_digest_defines.svh"
module md5_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	// The last flag marks exactly the fourth word.
	`MD5_ASSERT_IMP(a_last, clk, arst_n, m_tvalid, m_tlast == (m_tuser == 2'd3), "last flag")
	// Word indexes advance by one after each transaction but the last.
	`MD5_ASSERT_NEXT(a_idx, clk, arst_n, m_tvalid && m_tready && !m_tlast,
		m_tvalid && m_tuser == $past(m_tuser) + 2'd1, "index order")
	// A stalled result holds.
	`MD5_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stall hold")
endmodule

bind md5_message_digest md5_checker u_checker (.*);
